// ===== rtl/core/laser_command_line_parser_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the laser command line parser
// ---------------------------------------------------------------------------
`ifndef LASER_COMMAND_LINE_PARSER_UNIT_ASSERT_SVH
`define LASER_COMMAND_LINE_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define LCLP_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("lclp assertion failed");

// Next-cycle implication, disabled during reset
`define LCLP_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lclp assertion failed");

`endif

// ===== rtl/core/lclp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lclp_pkg
// Shared types, character codes and result codes of the command line parser.
// ---------------------------------------------------------------------------
package lclp_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  // Characters of interest
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_HASH    = 8'h23;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  // Search words, first character in the top byte
  localparam int          LASER_LEN  = 5;
  localparam logic [39:0] LASER_WORD = "LASER";
  localparam int          MOVE_LEN   = 4;
  localparam logic [31:0] MOVE_WORD  = "MOVE";
  localparam int          ON_LEN     = 2;
  localparam logic [15:0] ON_WORD    = "ON";
  localparam int          OFF_LEN    = 3;
  localparam logic [23:0] OFF_WORD   = "OFF";

  typedef enum logic [2:0] {
    ST_LASER     = 3'd0,
    ST_MOVE      = 3'd1,
    ST_EOF       = 3'd2,
    ST_INVALID   = 3'd3,
    ST_BAD_STATE = 3'd4,
    ST_NO_X      = 3'd5,
    ST_NO_Y      = 3'd6,
    ST_POS_ERR   = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    PH_SEEK_X = 3'd0,
    PH_IN_X   = 3'd1,
    PH_SEEK_Y = 3'd2,
    PH_IN_Y   = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  // Summary of the line so far, handed to the line judge
  typedef struct packed {
    logic   seen_laser;
    logic   seen_move;
    logic   seen_on;
    logic   seen_off;
    logic   digit_first;
    phase_t phase;
  } line_sum_t;

endpackage

// ===== rtl/core/laser_command_line_parser_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// laser_command_line_parser_unit
// Character-stream parser for LASER and MOVE command lines.
// ---------------------------------------------------------------------------
// Takes one character beat per clock and gives one result beat for each
// newline that closes a non-empty, non-comment line and for each end-of-text
// beat. Throughput is one character per cycle while the input is not
// stalled: the word matchers, the digit run tracker and the line flags all
// update in a single register stage, and the result of a line appears in
// the output register in the cycle after its newline is accepted. The input
// is stalled only while a result is held and the output side is stalling.
module laser_command_line_parser_unit #(
  parameter int COORD_WIDTH = lclp_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   text_valid,
  output logic                   text_stall,
  input  logic [7:0]             text_char,
  input  logic                   end_of_text,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [2:0]             status,
  output logic                   laser_on,
  output logic [COORD_WIDTH-1:0] coord_x,
  output logic [COORD_WIDTH-1:0] coord_y
);

`include "laser_command_line_parser_unit_assert.svh"

  logic                   accept;
  logic                   is_newline;
  logic                   line_clear;
  logic                   char_step;
  logic [7:0]             char_up;
  logic                   is_digit;
  logic [3:0]             digit;
  logic                   line_started;
  logic                   comment_line;
  logic                   digit_first;
  logic                   seen_laser;
  logic                   seen_move;
  logic                   seen_on;
  logic                   seen_off;
  lclp_pkg::phase_t       phase;
  logic [COORD_WIDTH-1:0] x_acc;
  logic [COORD_WIDTH-1:0] y_acc;
  lclp_pkg::line_sum_t    line_sum;
  lclp_pkg::status_t      judge_status;
  logic                   judge_laser_on;
  logic [COORD_WIDTH-1:0] judge_x;
  logic [COORD_WIDTH-1:0] judge_y;
  logic                   has_result;

  // Handshake: hold the input while a result waits on a stalled output
  assign text_stall = result_valid & result_stall;
  assign accept     = text_valid & ~text_stall;
  assign is_newline = (text_char == lclp_pkg::CHAR_NEWLINE);
  assign line_clear = accept & (end_of_text | is_newline);
  assign char_step  = accept & ~end_of_text & ~is_newline;

  // Fold lower case letters, classify digits
  assign char_up  = (text_char >= lclp_pkg::CHAR_LOWER_A && text_char <= lclp_pkg::CHAR_LOWER_Z)
                  ? text_char - lclp_pkg::CASE_OFFSET : text_char;
  assign is_digit = (char_up >= lclp_pkg::CHAR_ZERO) && (char_up <= lclp_pkg::CHAR_NINE);
  assign digit    = is_digit ? 4'(char_up - lclp_pkg::CHAR_ZERO) : 4'd0;

  // Line flags from the first character
  always_ff @(posedge clk) begin
    if (rst) begin
      line_started <= 1'b0;
      comment_line <= 1'b0;
      digit_first  <= 1'b0;
    end else if (line_clear) begin
      line_started <= 1'b0;
      comment_line <= 1'b0;
      digit_first  <= 1'b0;
    end else if (char_step && !line_started) begin
      line_started <= 1'b1;
      comment_line <= (char_up == lclp_pkg::CHAR_HASH);
      digit_first  <= is_digit;
    end
  end

  lclp_word_match #(.WORD_LEN(lclp_pkg::LASER_LEN), .WORD(lclp_pkg::LASER_WORD)) u_laser (
    .clk(clk), .rst(rst), .clear(line_clear), .step(char_step), .char_in(char_up),
    .seen(seen_laser)
  );

  lclp_word_match #(.WORD_LEN(lclp_pkg::MOVE_LEN), .WORD(lclp_pkg::MOVE_WORD)) u_move (
    .clk(clk), .rst(rst), .clear(line_clear), .step(char_step), .char_in(char_up),
    .seen(seen_move)
  );

  lclp_word_match #(.WORD_LEN(lclp_pkg::ON_LEN), .WORD(lclp_pkg::ON_WORD)) u_on (
    .clk(clk), .rst(rst), .clear(line_clear), .step(char_step), .char_in(char_up),
    .seen(seen_on)
  );

  lclp_word_match #(.WORD_LEN(lclp_pkg::OFF_LEN), .WORD(lclp_pkg::OFF_WORD)) u_off (
    .clk(clk), .rst(rst), .clear(line_clear), .step(char_step), .char_in(char_up),
    .seen(seen_off)
  );

  lclp_digit_track #(.COORD_WIDTH(COORD_WIDTH)) u_digits (
    .clk(clk), .rst(rst), .clear(line_clear), .step(char_step),
    .is_digit(is_digit), .digit(digit),
    .phase(phase), .x_acc(x_acc), .y_acc(y_acc)
  );

  // Summarise the line for the judge
  assign line_sum.seen_laser  = seen_laser;
  assign line_sum.seen_move   = seen_move;
  assign line_sum.seen_on     = seen_on;
  assign line_sum.seen_off    = seen_off;
  assign line_sum.digit_first = digit_first;
  assign line_sum.phase       = phase;

  lclp_line_judge #(.COORD_WIDTH(COORD_WIDTH)) u_judge (
    .line_sum(line_sum), .x_acc(x_acc), .y_acc(y_acc),
    .status(judge_status), .laser_on(judge_laser_on),
    .coord_x(judge_x), .coord_y(judge_y)
  );

  assign has_result = accept & (end_of_text | (is_newline & line_started & ~comment_line));

  // Result register: load a new beat, drop a taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (has_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (has_result) begin
      if (end_of_text) begin
        status   <= lclp_pkg::ST_EOF;
        laser_on <= 1'b0;
        coord_x  <= '0;
        coord_y  <= '0;
      end else begin
        status   <= judge_status;
        laser_on <= judge_laser_on;
        coord_x  <= judge_x;
        coord_y  <= judge_y;
      end
    end
  end

  // End of text always yields an end-of-file beat next cycle
  `LCLP_ASSERT_NEXT(a_eot_result, clk, rst, accept && end_of_text,
    result_valid && status == lclp_pkg::ST_EOF)
  // An ordinary character never yields a result
  `LCLP_ASSERT_NEXT(a_char_silent, clk, rst,
    accept && !end_of_text && text_char != lclp_pkg::CHAR_NEWLINE, !result_valid)
  // Laser state is only reported on a laser result
  `LCLP_ASSERT_NOW(a_laser_on_only, clk, rst,
    result_valid && status != lclp_pkg::ST_LASER, !laser_on)
  // Coordinates are zero unless a move result carries them
  `LCLP_ASSERT_NOW(a_coord_zero, clk, rst,
    result_valid && status != lclp_pkg::ST_MOVE && status != lclp_pkg::ST_POS_ERR,
    coord_x == '0 && coord_y == '0)

endmodule

// ===== rtl/core/lclp_word_match.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lclp_word_match
// Tracks the matched prefix of one search word and flags a full match.
// ---------------------------------------------------------------------------
module lclp_word_match #(
  parameter int                      WORD_LEN = 2,
  parameter logic [8*WORD_LEN-1:0]   WORD     = "ON"
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       clear,
  input  logic       step,
  input  logic [7:0] char_in,
  output logic       seen
);

  localparam int PW = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1;

  logic [PW-1:0] progress;
  logic [PW-1:0] progress_next;
  logic          seen_next;
  logic [7:0]    expect_char;
  logic [7:0]    first_char;

  // Pick the character the current prefix waits for
  assign expect_char = WORD[8*(WORD_LEN-1-int'(progress)) +: 8];
  assign first_char  = WORD[8*WORD_LEN-1 -: 8];

  // Advance on a match, restart on a mismatch
  always_comb begin
    progress_next = progress;
    seen_next     = seen;
    if (clear) begin
      progress_next = '0;
      seen_next     = 1'b0;
    end else if (step) begin
      if (char_in == expect_char) begin
        if (progress == PW'(WORD_LEN-1)) begin
          progress_next = '0;
          seen_next     = 1'b1;
        end else begin
          progress_next = progress + 1'b1;
        end
      end else if (char_in == first_char) begin
        progress_next = PW'(1);
      end else begin
        progress_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      progress <= '0;
      seen     <= 1'b0;
    end else begin
      progress <= progress_next;
      seen     <= seen_next;
    end
  end

endmodule

// ===== rtl/core/lclp_digit_track.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lclp_digit_track
// Follows the first two decimal digit runs of a line and accumulates them
// with saturation.
// ---------------------------------------------------------------------------
module lclp_digit_track #(
  parameter int COORD_WIDTH = lclp_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clear,
  input  logic                   step,
  input  logic                   is_digit,
  input  logic [3:0]             digit,
  output lclp_pkg::phase_t       phase,
  output logic [COORD_WIDTH-1:0] x_acc,
  output logic [COORD_WIDTH-1:0] y_acc
);

  localparam int WW = COORD_WIDTH + 4;

  lclp_pkg::phase_t       phase_next;
  logic [COORD_WIDTH-1:0] x_acc_next;
  logic [COORD_WIDTH-1:0] y_acc_next;
  logic [COORD_WIDTH-1:0] run_acc;
  logic [WW-1:0]          run_wide;
  logic [COORD_WIDTH-1:0] run_sat;

  // acc * 10 + digit, clamped at the coordinate maximum
  assign run_acc  = (phase == lclp_pkg::PH_IN_Y) ? y_acc : x_acc;
  assign run_wide = ({4'b0, run_acc} << 3) + ({4'b0, run_acc} << 1) + WW'(digit);
  assign run_sat  = (run_wide[WW-1:COORD_WIDTH] != '0) ? '1 : run_wide[COORD_WIDTH-1:0];

  // Step the run phase
  always_comb begin
    phase_next = phase;
    x_acc_next = x_acc;
    y_acc_next = y_acc;
    if (clear) begin
      phase_next = lclp_pkg::PH_SEEK_X;
      x_acc_next = '0;
      y_acc_next = '0;
    end else if (step) begin
      case (phase)
        lclp_pkg::PH_SEEK_X: begin
          if (is_digit) begin
            x_acc_next = COORD_WIDTH'(digit);
            phase_next = lclp_pkg::PH_IN_X;
          end
        end
        lclp_pkg::PH_IN_X: begin
          if (is_digit) x_acc_next = run_sat;
          else          phase_next = lclp_pkg::PH_SEEK_Y;
        end
        lclp_pkg::PH_SEEK_Y: begin
          if (is_digit) begin
            y_acc_next = COORD_WIDTH'(digit);
            phase_next = lclp_pkg::PH_IN_Y;
          end
        end
        lclp_pkg::PH_IN_Y: begin
          if (is_digit) y_acc_next = run_sat;
          else          phase_next = lclp_pkg::PH_DONE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lclp_pkg::PH_SEEK_X;
      x_acc <= '0;
      y_acc <= '0;
    end else begin
      phase <= phase_next;
      x_acc <= x_acc_next;
      y_acc <= y_acc_next;
    end
  end

endmodule

// ===== rtl/core/lclp_line_judge.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lclp_line_judge
// Turns the summary of a finished line into a status and its result fields.
// ---------------------------------------------------------------------------
module lclp_line_judge #(
  parameter int COORD_WIDTH = lclp_pkg::COORD_WIDTH_DEF
) (
  input  lclp_pkg::line_sum_t    line_sum,
  input  logic [COORD_WIDTH-1:0] x_acc,
  input  logic [COORD_WIDTH-1:0] y_acc,
  output lclp_pkg::status_t      status,
  output logic                   laser_on,
  output logic [COORD_WIDTH-1:0] coord_x,
  output logic [COORD_WIDTH-1:0] coord_y
);

  // LASER first, then MOVE, else invalid
  always_comb begin
    status   = lclp_pkg::ST_INVALID;
    laser_on = 1'b0;
    coord_x  = '0;
    coord_y  = '0;
    if (line_sum.seen_laser) begin
      if (line_sum.seen_on) begin
        status   = lclp_pkg::ST_LASER;
        laser_on = 1'b1;
      end else if (line_sum.seen_off) begin
        status   = lclp_pkg::ST_LASER;
      end else begin
        status   = lclp_pkg::ST_BAD_STATE;
      end
    end else if (line_sum.seen_move) begin
      case (line_sum.phase)
        lclp_pkg::PH_SEEK_X: begin
          status = lclp_pkg::ST_NO_X;
        end
        lclp_pkg::PH_IN_X, lclp_pkg::PH_SEEK_Y: begin
          status = lclp_pkg::ST_NO_Y;
        end
        default: begin
          status  = line_sum.digit_first ? lclp_pkg::ST_POS_ERR : lclp_pkg::ST_MOVE;
          coord_x = x_acc;
          coord_y = y_acc;
        end
      endcase
    end
  end

endmodule
